// File: src/prq_pkg.sv
// Shared types, constants and helpers for the priority ready queue scheduler.
`timescale 1ns / 1ps

package prq_pkg;

  localparam int THREADS = 8;
  localparam int LEVELS = 16;
  localparam int ID_W = $clog2(THREADS);
  localparam int LVL_W = $clog2(LEVELS);

  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_YIELD = 3'd1;
  localparam logic [2:0] REQ_SLEEP = 3'd2;
  localparam logic [2:0] REQ_WAKE = 3'd3;
  localparam logic [2:0] REQ_GETID = 3'd4;
  localparam logic [2:0] REQ_CHPRI = 3'd5;
  localparam logic [2:0] REQ_EXIT = 3'd6;
  localparam logic [2:0] REQ_INT = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BADTGT = 2'd2;
  localparam logic [1:0] ST_HALT = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] new_priority;
    logic       keep_priority;
    logic [2:0] target_thread;
  } sched_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] ret_thread;
    logic [3:0] ret_priority;
    logic [2:0] running_thread;
    logic       halted;
  } sched_res_t;

  typedef enum logic [2:0] {
    Q_NOP,
    Q_TAKE,
    Q_ENQ,
    Q_CREATE,
    Q_SETPRI,
    Q_FREE
  } q_op_t;

  typedef struct packed {
    q_op_t             op;
    logic [ID_W-1:0]   id;
    logic [3:0]        pri;
    logic [ID_W-1:0]   rd_id;
  } q_cmd_t;

  typedef struct packed {
    logic              any_free;
    logic [ID_W-1:0]   free_id;
    logic              any_ready;
    logic [ID_W-1:0]   pick_id;
    logic              rd_in_use;
    logic [LVL_W-1:0]  rd_prio;
  } q_stat_t;

  function automatic logic [LVL_W-1:0] clamp_level(input logic [3:0] p);
    logic [LVL_W-1:0] r;
    if (32'(p) >= LEVELS) begin
      r = LVL_W'(LEVELS - 1);
    end else begin
      r = LVL_W'(p);
    end
    return r;
  endfunction

endpackage

// File: src/priority_ready_queue_scheduler.sv
// Top level of the priority ready queue scheduler: event sequencer and result register.
`timescale 1ns / 1ps

// A kernel event is one beat on req, taken at a rising edge with start high and busy low.
// Busy then stays high until the cycle in which done is high. Each event gives exactly one
// result beat on result, marked by done for a single cycle; the receiver cannot stall it.
// An event passes through a take state that takes the running thread off its queue, a
// request state, up to two states for queue insertions (create, wake, change priority),
// and a pick state that takes the head of the lowest-numbered non-empty priority queue.
// The single queue unit behind these states performs one queue operation per cycle.
// Once halted, an event returns the halt result from the take state. Busy is already
// low while done is high, so a new event may be accepted at the edge that ends the done
// cycle. Synchronous reset empties every queue, frees all thread slots, clears the
// running thread and the halt flag; the block is idle as soon as reset is released.
module priority_ready_queue_scheduler import prq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  sched_req_t req,
  output logic       busy,
  output logic       done,
  output sched_res_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_OP,
    S_ENQ1,
    S_ENQ2,
    S_PICK
  } state_t;

  localparam sched_res_t RES_HALTED = '{status: ST_HALT, ret_thread: 3'd0,
                                       ret_priority: 4'd0, running_thread: 3'd0,
                                       halted: 1'b1};

  state_t          state;
  sched_req_t      req_q;
  logic            run_valid;
  logic [ID_W-1:0] run_id;
  logic            halt_flag;
  logic [1:0]      status_q;
  logic [2:0]      ret_thread_q;
  logic [3:0]      ret_prio_q;
  logic            second_ok;
  logic [ID_W-1:0] second_id;
  q_cmd_t          cmd;
  q_stat_t         stat;
  logic            target_ok;

  assign busy = (state != S_IDLE);
  assign target_ok = (32'(req_q.target_thread) < THREADS) && stat.rd_in_use;

  prq_queue_unit u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  always_comb begin
    cmd.op = Q_NOP;
    cmd.id = run_id;
    cmd.pri = req_q.new_priority;
    cmd.rd_id = run_id;
    case (state)
      S_TAKE: begin
        if (!halt_flag && req_q.req_type != REQ_INT && run_valid) begin
          cmd.op = Q_TAKE;
        end
      end
      S_OP: begin
        case (req_q.req_type)
          REQ_CREATE: begin
            if (stat.any_free) begin
              cmd.op = Q_CREATE;
              cmd.id = stat.free_id;
            end
          end
          REQ_WAKE: begin
            cmd.rd_id = ID_W'(req_q.target_thread);
            if (run_valid) begin
              cmd.op = Q_ENQ;
            end
          end
          REQ_YIELD, REQ_GETID: begin
            if (run_valid) begin
              cmd.op = Q_ENQ;
            end
          end
          REQ_CHPRI: begin
            if (run_valid && !req_q.keep_priority) begin
              cmd.op = Q_SETPRI;
            end
          end
          REQ_EXIT: begin
            if (run_valid) begin
              cmd.op = Q_FREE;
            end
          end
          default: begin
          end
        endcase
      end
      S_ENQ1: begin
        if (run_valid) begin
          cmd.op = Q_ENQ;
        end
      end
      S_ENQ2: begin
        if (second_ok) begin
          cmd.op = Q_ENQ;
          cmd.id = second_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      run_valid <= 1'b0;
      halt_flag <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            status_q <= ST_OK;
            ret_thread_q <= 3'd0;
            ret_prio_q <= 4'd0;
            second_ok <= 1'b0;
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          if (halt_flag) begin
            result <= RES_HALTED;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_OP;
          end
        end
        S_OP: begin
          case (req_q.req_type)
            REQ_CREATE: begin
              if (stat.any_free) begin
                ret_thread_q <= 3'(stat.free_id);
                second_ok <= 1'b1;
                second_id <= stat.free_id;
              end else begin
                status_q <= ST_NOFREE;
              end
              state <= S_ENQ1;
            end
            REQ_WAKE: begin
              if (target_ok) begin
                second_ok <= 1'b1;
                second_id <= ID_W'(req_q.target_thread);
              end else begin
                status_q <= ST_BADTGT;
              end
              state <= S_ENQ2;
            end
            REQ_GETID: begin
              if (run_valid) begin
                ret_thread_q <= 3'(run_id);
              end
              state <= S_PICK;
            end
            REQ_CHPRI: begin
              if (run_valid) begin
                ret_prio_q <= 4'(stat.rd_prio);
              end
              state <= S_ENQ1;
            end
            default: begin
              state <= S_PICK;
            end
          endcase
        end
        S_ENQ1: begin
          if (req_q.req_type == REQ_CREATE) begin
            state <= S_ENQ2;
          end else begin
            state <= S_PICK;
          end
        end
        S_ENQ2: begin
          state <= S_PICK;
        end
        S_PICK: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (stat.any_ready) begin
            run_valid <= 1'b1;
            run_id <= stat.pick_id;
            result <= '{status: status_q, ret_thread: ret_thread_q,
                        ret_priority: ret_prio_q, running_thread: 3'(stat.pick_id),
                        halted: 1'b0};
          end else begin
            halt_flag <= 1'b1;
            run_valid <= 1'b0;
            result <= RES_HALTED;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat shown while an event is still in progress");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag cleared without reset");

  a_halt_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.halted) |-> (result.status == ST_HALT && result.running_thread == 3'd0))
    else $error("halted result beat carries wrong fields");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted event did not raise busy");
`endif

endmodule

// File: src/prq_queue_unit.sv
// Ready queue store and the shared unit that applies one queue operation per cycle.
`timescale 1ns / 1ps

module prq_queue_unit import prq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_cmd_t  cmd,
  output q_stat_t stat
);

  logic [THREADS-1:0] in_use;
  logic [THREADS-1:0] ready;
  logic [THREADS-1:0] has_nxt;
  logic [LVL_W-1:0]   prio [THREADS];
  logic [ID_W-1:0]    nxt [THREADS];
  logic [ID_W-1:0]    head [LEVELS];
  logic [ID_W-1:0]    tail [LEVELS];
  logic [LEVELS-1:0]  nonempty;
  logic [LVL_W-1:0]   lv;
  logic [LVL_W-1:0]   pick_lv;

  assign lv = prio[cmd.id];

  always_comb begin
    stat.any_free = 1'b0;
    stat.free_id = '0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        stat.any_free = 1'b1;
        stat.free_id = ID_W'(i);
      end
    end
    pick_lv = '0;
    for (int j = LEVELS - 1; j >= 0; j--) begin
      if (nonempty[j]) begin
        pick_lv = LVL_W'(j);
      end
    end
    stat.any_ready = |nonempty;
    stat.pick_id = head[pick_lv];
    stat.rd_in_use = in_use[cmd.rd_id];
    stat.rd_prio = prio[cmd.rd_id];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      ready <= '0;
      has_nxt <= '0;
      nonempty <= '0;
      for (int i = 0; i < THREADS; i++) begin
        prio[i] <= '0;
      end
    end else begin
      case (cmd.op)
        Q_TAKE: begin
          if (ready[cmd.id]) begin
            if (!has_nxt[cmd.id]) begin
              nonempty[lv] <= 1'b0;
            end
            ready[cmd.id] <= 1'b0;
            has_nxt[cmd.id] <= 1'b0;
          end
        end
        Q_ENQ: begin
          if (!ready[cmd.id]) begin
            has_nxt[cmd.id] <= 1'b0;
            if (nonempty[lv]) begin
              has_nxt[tail[lv]] <= 1'b1;
            end
            nonempty[lv] <= 1'b1;
            ready[cmd.id] <= 1'b1;
          end
        end
        Q_CREATE: begin
          in_use[cmd.id] <= 1'b1;
          ready[cmd.id] <= 1'b0;
          has_nxt[cmd.id] <= 1'b0;
          prio[cmd.id] <= clamp_level(cmd.pri);
        end
        Q_SETPRI: begin
          prio[cmd.id] <= clamp_level(cmd.pri);
        end
        Q_FREE: begin
          in_use[cmd.id] <= 1'b0;
          ready[cmd.id] <= 1'b0;
          has_nxt[cmd.id] <= 1'b0;
          prio[cmd.id] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      Q_TAKE: begin
        if (ready[cmd.id] && has_nxt[cmd.id]) begin
          head[lv] <= nxt[cmd.id];
        end
      end
      Q_ENQ: begin
        if (!ready[cmd.id]) begin
          if (nonempty[lv]) begin
            nxt[tail[lv]] <= cmd.id;
          end else begin
            head[lv] <= cmd.id;
          end
          tail[lv] <= cmd.id;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_in_use: assert property (@(posedge clk) disable iff (rst)
    (ready & ~in_use) == '0)
    else $error("ready thread slot is not in use");

  a_pick_ready: assert property (@(posedge clk) disable iff (rst)
    stat.any_ready |-> ready[stat.pick_id])
    else $error("head of the chosen level is not ready");

  a_enq_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == Q_ENQ && !ready[cmd.id]) |=> ready[$past(cmd.id)])
    else $error("enqueued thread did not become ready");
`endif

endmodule
